// ----- rtl/dark_blob_pupil_locator_unit_defines.svh -----
// Assertion macros shared by the pupil locator RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef DARK_BLOB_PUPIL_LOCATOR_UNIT_DEFINES_SVH
`define DARK_BLOB_PUPIL_LOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DBPL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("dbpl assertion failed");
`define DBPL_ASSERT_NEXT(name, clk, rst, cond, expct) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expct)) \
   else $error("dbpl assertion failed");
`else
`define DBPL_ASSERT(name, clk, rst, prop)
`define DBPL_ASSERT_NEXT(name, clk, rst, cond, expct)
`endif
`endif

// ----- rtl/dbpl_pkg.sv -----
// Shared types, constants and helper functions of the pupil locator.
// No dependencies.
`default_nettype none
package dbpl_pkg;
   localparam int FRAME_WIDTH  = 96;
   localparam int FRAME_HEIGHT = 96;
   localparam int BOX_SLOTS    = 50;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   localparam logic [2:0] CSR_THRESHOLD_FRACTION = 3'd0;
   localparam logic [2:0] CSR_NEAR_RADIUS        = 3'd1;
   localparam logic [2:0] CSR_MIN_AREA           = 3'd2;
   localparam logic [2:0] CSR_TARGET_X           = 3'd3;
   localparam logic [2:0] CSR_TARGET_Y           = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  x;
      logic [6:0]  y;
      logic        claimed;
      logic        found;
      logic [14:0] best_d;
      logic [6:0]  bx;
      logic [6:0]  by;
      logic [6:0]  count;
      logic [7:0]  low;
      logic [7:0]  high;
   } tok_type;

   typedef struct packed {
      logic [13:0] r2;
      logic [13:0] min_area;
      logic [6:0]  tx;
      logic [6:0]  ty;
   } cfg_type;

   function automatic logic [6:0] gap(input logic [6:0] lo, input logic [6:0] hi,
                                      input logic [6:0] p);
      logic [6:0] r;
      if (p < lo) r = lo - p;
      else if (p > hi) r = p - hi;
      else r = 7'd0;
      return r;
   endfunction

   function automatic logic [6:0] absdiff(input logic [6:0] a, input logic [6:0] b);
      return (a > b) ? a - b : b - a;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/dbpl_cell.sv -----
// One box slot of the matching chain: holds a box and passes a token on.
// Depends on dbpl_pkg and the assertion macro header.
`default_nettype none
`include "dark_blob_pupil_locator_unit_defines.svh"
module dbpl_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire dbpl_pkg::cfg_type cfg,
   input  wire dbpl_pkg::tok_type tok_in,
   output dbpl_pkg::tok_type      tok_out
);
   logic             valid_ff, valid_in;
   logic [6:0]       x0_ff, y0_ff, x1_ff, y1_ff;
   logic [6:0]       x0_in, y0_in, x1_in, y1_in;
   dbpl_pkg::tok_type tok_ff, tok_in_nx;

   logic [6:0]  dx, dy, w, h, cx, cy, dcx, dcy;
   logic [7:0]  sx, sy;
   logic [14:0] gap_sq, d;
   logic [13:0] area;
   logic        hit, qual;

   always_comb begin
      dx     = dbpl_pkg::gap(x0_ff, x1_ff, tok_in.x);
      dy     = dbpl_pkg::gap(y0_ff, y1_ff, tok_in.y);
      gap_sq = {1'b0, {7'd0, dx} * {7'd0, dx}} + {1'b0, {7'd0, dy} * {7'd0, dy}};
      hit    = valid_ff && (gap_sq < {1'b0, cfg.r2});
      w      = x1_ff - x0_ff;
      h      = y1_ff - y0_ff;
      area   = {7'd0, w} * {7'd0, h};
      qual   = valid_ff && (area > cfg.min_area);
      sx     = {1'b0, x0_ff} + {1'b0, x1_ff};
      sy     = {1'b0, y0_ff} + {1'b0, y1_ff};
      cx     = sx[7:1];
      cy     = sy[7:1];
      dcx    = dbpl_pkg::absdiff(cx, cfg.tx);
      dcy    = dbpl_pkg::absdiff(cy, cfg.ty);
      d      = {1'b0, {7'd0, dcx} * {7'd0, dcx}} + {1'b0, {7'd0, dcy} * {7'd0, dcy}};

      valid_in  = valid_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      tok_in_nx = tok_in;
      if (tok_in.kind == dbpl_pkg::KIND_PIXEL && !tok_in.claimed) begin
         if (hit) begin
            if (tok_in.x < x0_ff) x0_in = tok_in.x;
            if (tok_in.y < y0_ff) y0_in = tok_in.y;
            if (tok_in.x > x1_ff) x1_in = tok_in.x;
            if (tok_in.y > y1_ff) y1_in = tok_in.y;
            tok_in_nx.claimed = 1'b1;
         end else if (!valid_ff) begin
            valid_in = 1'b1;
            x0_in = tok_in.x;
            x1_in = tok_in.x;
            y0_in = tok_in.y;
            y1_in = tok_in.y;
            tok_in_nx.claimed = 1'b1;
         end
      end else if (tok_in.kind == dbpl_pkg::KIND_SEARCH) begin
         valid_in = 1'b0;
         if (valid_ff) tok_in_nx.count = tok_in.count + 7'd1;
         if (qual && (!tok_in.found || d < tok_in.best_d)) begin
            tok_in_nx.found  = 1'b1;
            tok_in_nx.best_d = d;
            tok_in_nx.bx     = cx;
            tok_in_nx.by     = cy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.kind <= dbpl_pkg::KIND_NONE;
      end else if (en) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
      end
   end

   assign tok_out = tok_ff;

   `DBPL_ASSERT_NEXT(a_search_clears, clock, reset,
      en && tok_in.kind == dbpl_pkg::KIND_SEARCH, !valid_ff)
   `DBPL_ASSERT_NEXT(a_claim_kept, clock, reset,
      en && tok_in.kind == dbpl_pkg::KIND_PIXEL && tok_in.claimed, tok_ff.claimed)
endmodule
`default_nettype wire

// ----- rtl/dark_blob_pupil_locator_unit.sv -----
// Top level of the dark blob pupil locator: input stage, cell chain, result stage.
// Depends on dbpl_pkg, dbpl_cell and the assertion macro header.
//
// Pixels enter one per cycle in raster order unless stalled; each black pixel
// travels as a beat down a chain of BOX_SLOTS cells, one cell per cycle while
// the chain runs, and joins or opens the first matching box. After a frame_last
// pixel the input takes no beat while a search beat is launched; it scans and
// clears every cell, and its result is registered after the chain. Input rate
// is one pixel per cycle but for each frame's search beat; the chain stalls only
// while a result waits on rsp_tready. No clearing pass is needed after reset.
`default_nettype none
`include "dark_blob_pupil_locator_unit_defines.svh"
module dark_blob_pupil_locator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // pixel
   input  wire logic        req_tlast,   // frame_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pupil_x, pupil_y, pupil_found, blob_total, blob_overflow, frame_low, frame_high
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [13:0] csr_wdata
);
   logic [7:0]  frac_ff;
   logic [6:0]  radius_ff, tx_ff, ty_ff;
   logic [13:0] min_area_ff, r2_ff;
   logic [7:0]  prev_low_ff, prev_high_ff, run_low_ff, run_high_ff;
   logic [7:0]  run_low_in, run_high_in, fl_low_ff, fl_high_ff;
   logic [6:0]  col_ff, row_ff;
   logic        search_pend_ff, ovf_ff, rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic        en, req_accept, black;
   logic [7:0]  range_v;
   logic [15:0] prod;
   logic [8:0]  thr;
   logic [5:0]  total;
   dbpl_pkg::tok_type tok0_ff, tok0_in, end_tok;
   dbpl_pkg::tok_type chain [0:dbpl_pkg::BOX_SLOTS];
   dbpl_pkg::cfg_type cfg;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && !search_pend_ff;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff     <= 8'd26;
         radius_ff   <= 7'd5;
         min_area_ff <= 14'd10;
         tx_ff       <= 7'd48;
         ty_ff       <= 7'd48;
      end else if (csr_wen) begin
         unique case (csr_addr)
            dbpl_pkg::CSR_THRESHOLD_FRACTION: frac_ff     <= csr_wdata[7:0];
            dbpl_pkg::CSR_NEAR_RADIUS:        radius_ff   <= csr_wdata[6:0];
            dbpl_pkg::CSR_MIN_AREA:           min_area_ff <= csr_wdata;
            dbpl_pkg::CSR_TARGET_X:           tx_ff       <= csr_wdata[6:0];
            dbpl_pkg::CSR_TARGET_Y:           ty_ff       <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= {7'd0, radius_ff} * {7'd0, radius_ff};
   end

   always_comb begin
      range_v     = (prev_high_ff >= prev_low_ff) ? prev_high_ff - prev_low_ff : 8'd0;
      prod        = frac_ff * range_v;
      thr         = {1'b0, prev_low_ff} + {1'b0, prod[15:8]};
      black       = {1'b0, req_tdata} <= thr;
      run_low_in  = (req_tdata < run_low_ff) ? req_tdata : run_low_ff;
      run_high_in = (req_tdata > run_high_ff) ? req_tdata : run_high_ff;

      tok0_in         = tok0_ff;
      tok0_in.kind    = dbpl_pkg::KIND_NONE;
      tok0_in.claimed = 1'b0;
      if (search_pend_ff) begin
         tok0_in.kind   = dbpl_pkg::KIND_SEARCH;
         tok0_in.found  = 1'b0;
         tok0_in.best_d = 15'd0;
         tok0_in.bx     = tx_ff;
         tok0_in.by     = ty_ff;
         tok0_in.count  = 7'd0;
         tok0_in.low    = fl_low_ff;
         tok0_in.high   = fl_high_ff;
      end else if (req_accept && black) begin
         tok0_in.kind = dbpl_pkg::KIND_PIXEL;
         tok0_in.x    = col_ff;
         tok0_in.y    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_low_ff    <= 8'd0;
         prev_high_ff   <= 8'd255;
         run_low_ff     <= 8'd255;
         run_high_ff    <= 8'd0;
         col_ff         <= 7'd0;
         row_ff         <= 7'd0;
         search_pend_ff <= 1'b0;
         tok0_ff.kind   <= dbpl_pkg::KIND_NONE;
      end else if (en) begin
         tok0_ff <= tok0_in;
         if (search_pend_ff) search_pend_ff <= 1'b0;
         if (req_accept) begin
            if (req_tlast) begin
               prev_low_ff    <= run_low_in;
               prev_high_ff   <= run_high_in;
               run_low_ff     <= 8'd255;
               run_high_ff    <= 8'd0;
               col_ff         <= 7'd0;
               row_ff         <= 7'd0;
               search_pend_ff <= 1'b1;
            end else begin
               run_low_ff  <= run_low_in;
               run_high_ff <= run_high_in;
               if ({1'b0, col_ff} + 8'd1 >= 8'(dbpl_pkg::FRAME_WIDTH)) begin
                  col_ff <= 7'd0;
                  if ({1'b0, row_ff} + 8'd1 < 8'(dbpl_pkg::FRAME_HEIGHT))
                     row_ff <= row_ff + 7'd1;
               end else begin
                  col_ff <= col_ff + 7'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && req_accept && req_tlast) begin
         fl_low_ff  <= run_low_in;
         fl_high_ff <= run_high_in;
      end
   end

   assign cfg.r2       = r2_ff;
   assign cfg.min_area = min_area_ff;
   assign cfg.tx       = tx_ff;
   assign cfg.ty       = ty_ff;
   assign chain[0]     = tok0_ff;

   for (genvar i = 0; i < dbpl_pkg::BOX_SLOTS; i++) begin : g_cell
      dbpl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .cfg     (cfg),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   assign end_tok = chain[dbpl_pkg::BOX_SLOTS];
   assign total   = (end_tok.count > 7'd63) ? 6'd63 : end_tok.count[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= end_tok.kind == dbpl_pkg::KIND_SEARCH;
         if (end_tok.kind == dbpl_pkg::KIND_SEARCH) ovf_ff <= 1'b0;
         else if (end_tok.kind == dbpl_pkg::KIND_PIXEL && !end_tok.claimed) ovf_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en && end_tok.kind == dbpl_pkg::KIND_SEARCH) begin
         rsp_data_ff <= {2'b00, end_tok.high, end_tok.low, ovf_ff, total,
                         end_tok.found, end_tok.by, end_tok.bx};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `DBPL_ASSERT_NEXT(a_bubble_after_last, clock, reset,
      req_accept && req_tlast, !req_tready)
   `DBPL_ASSERT_NEXT(a_result_loads, clock, reset,
      en && end_tok.kind == dbpl_pkg::KIND_SEARCH, rsp_valid_ff && !ovf_ff)
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for dark_blob_pupil_locator_unit: drives pixel frames
// and register settings, predicts each frame result and compares it field by field.
// Depends on dbpl_pkg and the RTL of the unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [6:0] px;
      logic [6:0] py;
      logic       found;
      logic [5:0] total;
      logic       ovf;
      logic [7:0] low;
      logic [7:0] high;
   } pupil_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // pixel
   logic        req_tlast = 1'b0;   // frame_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // pupil_x, pupil_y, pupil_found, blob_total, blob_overflow, frame_low, frame_high
   logic [39:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_addr = 3'd0;
   logic [13:0] csr_wdata = 14'd0;

   dark_blob_pupil_locator_unit u_top (.*);

   initial forever #2 clock = ~clock;

   int unsigned fraction_r, radius_r, area_r, tx_r, ty_r;
   int unsigned prev_low, prev_high, run_low, run_high, col_cnt, row_cnt, box_cnt, ovf_seen;
   int unsigned bx0[dbpl_pkg::BOX_SLOTS], by0[dbpl_pkg::BOX_SLOTS];
   int unsigned bx1[dbpl_pkg::BOX_SLOTS], by1[dbpl_pkg::BOX_SLOTS];
   pupil_t pupil_q[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned send_idle = 0, recv_idle = 0;

   function automatic int unsigned gap_to(int unsigned lo, int unsigned hi, int unsigned p);
      if (p < lo) return lo - p;
      if (p > hi) return p - hi;
      return 0;
   endfunction

   function automatic int unsigned sq_dist(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   task automatic clear_frame();
      run_low = 255;
      run_high = 0;
      col_cnt = 0;
      row_cnt = 0;
      box_cnt = 0;
      ovf_seen = 0;
   endtask

   task automatic place_black(int unsigned x, int unsigned y);
      int unsigned r2, dx, dy;
      r2 = radius_r * radius_r;
      for (int i = 0; i < box_cnt; i++) begin
         dx = gap_to(bx0[i], bx1[i], x);
         dy = gap_to(by0[i], by1[i], y);
         if (dx * dx + dy * dy < r2) begin
            if (x < bx0[i]) bx0[i] = x;
            if (y < by0[i]) by0[i] = y;
            if (x > bx1[i]) bx1[i] = x;
            if (y > by1[i]) by1[i] = y;
            return;
         end
      end
      if (box_cnt >= dbpl_pkg::BOX_SLOTS) begin
         ovf_seen = 1;
         return;
      end
      bx0[box_cnt] = x;
      by0[box_cnt] = y;
      bx1[box_cnt] = x;
      by1[box_cnt] = y;
      box_cnt++;
   endtask

   task automatic predict_pixel(int unsigned pix, bit last);
      int unsigned range, thr, best_d, cx, cy, d, area;
      pupil_t r;
      range = (prev_high >= prev_low) ? prev_high - prev_low : 0;
      thr = prev_low + ((fraction_r * range) >> 8);
      if (pix < run_low) run_low = pix;
      if (pix > run_high) run_high = pix;
      if (pix <= thr) place_black(col_cnt, row_cnt);
      if (col_cnt + 1 >= dbpl_pkg::FRAME_WIDTH) begin
         col_cnt = 0;
         if (row_cnt + 1 < dbpl_pkg::FRAME_HEIGHT) row_cnt++;
      end else begin
         col_cnt++;
      end
      if (!last) return;
      r.px = 7'(tx_r);
      r.py = 7'(ty_r);
      r.found = 1'b0;
      best_d = 0;
      for (int i = 0; i < box_cnt; i++) begin
         area = (bx1[i] - bx0[i]) * (by1[i] - by0[i]);
         if (area > area_r) begin
            cx = (bx0[i] + bx1[i]) >> 1;
            cy = (by0[i] + by1[i]) >> 1;
            d = sq_dist(cx, tx_r) + sq_dist(cy, ty_r);
            if (!r.found || d < best_d) begin
               r.found = 1'b1;
               best_d = d;
               r.px = 7'(cx);
               r.py = 7'(cy);
            end
         end
      end
      r.total = 6'((box_cnt > 63) ? 63 : box_cnt);
      r.ovf = ovf_seen[0];
      r.low = 8'(run_low);
      r.high = 8'(run_high);
      pupil_q.push_back(r);
      prev_low = run_low;
      prev_high = run_high;
      clear_frame();
   endtask

   always @(posedge clock) begin
      pupil_t e;
      logic [39:0] a;
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) predict_pixel(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = rsp_tdata;
         if (pupil_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", a);
         end else begin
            e = pupil_q.pop_front();
            if (a[6:0] !== e.px || a[13:7] !== e.py || a[14] !== e.found ||
                a[20:15] !== e.total || a[21] !== e.ovf || a[29:22] !== e.low ||
                a[37:30] !== e.high) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%0d y=%0d f=%0d n=%0d o=%0d lo=%0d hi=%0d, got %h",
                           e.px, e.py, e.found, e.total, e.ovf, e.low, e.high, a);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock)
      if (cycles > 600000) begin
         $display("FAIL");
         $finish;
      end

   task automatic write_reg(logic [2:0] idx, int unsigned val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= 14'(val);
      case (idx)
         dbpl_pkg::CSR_THRESHOLD_FRACTION: fraction_r = val & 8'hFF;
         dbpl_pkg::CSR_NEAR_RADIUS:        radius_r = val & 7'h7F;
         dbpl_pkg::CSR_MIN_AREA:           area_r = val & 14'h3FFF;
         dbpl_pkg::CSR_TARGET_X:           tx_r = val & 7'h7F;
         dbpl_pkg::CSR_TARGET_Y:           ty_r = val & 7'h7F;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic send_pixel(int unsigned pix, bit last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= 8'(pix);
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pupil_q.size() != 0) @(posedge clock);
      repeat (dbpl_pkg::BOX_SLOTS + 10) @(posedge clock);
   endtask

   task automatic set_all(int unsigned f, int unsigned r, int unsigned m,
                          int unsigned x, int unsigned y);
      write_reg(dbpl_pkg::CSR_THRESHOLD_FRACTION, f);
      write_reg(dbpl_pkg::CSR_NEAR_RADIUS, r);
      write_reg(dbpl_pkg::CSR_MIN_AREA, m);
      write_reg(dbpl_pkg::CSR_TARGET_X, x);
      write_reg(dbpl_pkg::CSR_TARGET_Y, y);
   endtask

   task automatic send_frame(int unsigned len, int unsigned dark_pct);
      for (int i = 0; i < len; i++)
         send_pixel(($urandom_range(99) < dark_pct) ? $urandom_range(40) : $urandom_range(255),
                    i == len - 1);
   endtask

   task automatic test_directed();
      send_pixel(0, 1'b1);
      send_pixel(255, 1'b0);
      send_pixel(0, 1'b0);
      send_pixel(128, 1'b1);
      drain();
      set_all(255, 95, 0, 0, 0);
      for (int i = 0; i < 8; i++) send_pixel(i[0] ? 255 : 0, i == 7);
      drain();
      set_all(0, 0, 9025, 95, 95);
      send_frame(6, 50);
      drain();
   endtask

   task automatic test_table_full();
      set_all(255, 0, 0, 95, 0);
      send_pixel(0, 1'b0);
      send_pixel(255, 1'b1);
      for (int i = 0; i < 60; i++) send_pixel(0, i == 59);
      drain();
   endtask

   task automatic test_row_wrap();
      set_all(26, 5, 10, 48, 48);
      for (int i = 0; i < 3 * dbpl_pkg::FRAME_WIDTH + 5; i++)
         send_pixel((i % 7 == 0) ? 0 : 200 + $urandom_range(55),
                    i == 3 * dbpl_pkg::FRAME_WIDTH + 4);
      drain();
   endtask

   task automatic test_random(int unsigned s_idle, int unsigned r_idle);
      int unsigned items;
      int unsigned len;
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int k = 0; k < 3; k++) begin
         if (k == 0) set_all(0, 95, 9025, 0, 95);
         else set_all($urandom_range(255), $urandom_range(95), $urandom_range(60),
                      $urandom_range(95), $urandom_range(95));
         items = 0;
         while (items < 90) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 80);
            send_frame(len, $urandom_range(5, 60));
            items += len;
         end
         drain();
      end
   endtask

   initial begin
      fraction_r = 26;
      radius_r = 5;
      area_r = 10;
      tx_r = 48;
      ty_r = 48;
      prev_low = 0;
      prev_high = 255;
      clear_frame();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 9;
      recv_idle = 87;
      test_directed();
      test_table_full();
      test_row_wrap();
      test_random(9, 87);
      test_random(87, 9);
      test_random(0, 0);
      if (mismatches == 0 && pupil_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
